/* rtl/core/rtms_pkg.sv */
// ----------------------------------------------------------------------------
// rtms_pkg
// Shared constants and controller/datapath interface types for the trimmed
// mean and standard deviation unit.
// ----------------------------------------------------------------------------
package rtms_pkg;

    localparam int unsigned MAX_SAMPLES = 65536;
    localparam int unsigned SAMPLE_W    = 24;
    localparam int unsigned ADDR_W      = 16;
    localparam int unsigned CNT_W       = 17;
    localparam int unsigned SUM_W       = 41;
    localparam int unsigned SS_W        = 64;
    localparam int unsigned ITER_W      = 6;

    typedef enum logic [1:0] {
        SCAN_SEL = 2'd0,
        SCAN_SUM = 2'd1,
        SCAN_SQ  = 2'd2
    } t_scan_mode;

    typedef struct packed {
        logic              load;
        logic              k_init;
        logic              scan_go;
        t_scan_mode        scan_mode;
        logic              sel_upd;
        logic              bounds;
        logic              div_init;
        logic              div_sel_ss;
        logic              div_step;
        logic              mean_take;
        logic              sqrt_init;
        logic              sqrt_step;
        logic              set_clear;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic n_zero;
        logic scan_busy;
        logic kept_zero;
        logic kept_lt2;
    } t_sts;

endpackage

/* rtl/core/rtms_ctrl.sv */
// ----------------------------------------------------------------------------
// rtms_ctrl
// Sequencer: load phase, order statistic passes, filter pass, mean division,
// squared deviation pass, variance division, square root and result strobe.
// ----------------------------------------------------------------------------
module rtms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_last,
    input  rtms_pkg::t_sts i_sts,
    output rtms_pkg::t_cmd o_cmd,
    output logic           busy,
    output logic           o_valid
);

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_KINIT  = 18'h00002,
        S_SGO    = 18'h00004,
        S_SWAIT  = 18'h00008,
        S_SUPD   = 18'h00010,
        S_BOUNDS = 18'h00020,
        S_AGO    = 18'h00040,
        S_AWAIT  = 18'h00080,
        S_MINIT  = 18'h00100,
        S_MDIV   = 18'h00200,
        S_MTAKE  = 18'h00400,
        S_QGO    = 18'h00800,
        S_QWAIT  = 18'h01000,
        S_VINIT  = 18'h02000,
        S_VDIV   = 18'h04000,
        S_RINIT  = 18'h08000,
        S_ROOT   = 18'h10000,
        S_OUT    = 18'h20000
    } t_state;

    t_state                      r_state, n_state;
    logic [rtms_pkg::ITER_W-1:0] r_iter, n_iter;

    always_comb begin
        n_state = r_state;
        n_iter  = r_iter;
        o_cmd   = '0;
        o_cmd.iter      = r_iter;
        o_cmd.scan_mode = rtms_pkg::SCAN_SEL;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = start;
                if (start && i_last) begin
                    n_state = S_KINIT;
                end
            end
            S_KINIT: begin
                o_cmd.k_init = 1'b1;
                n_iter = rtms_pkg::ITER_W'(rtms_pkg::SAMPLE_W - 1);
                n_state = i_sts.n_zero ? S_OUT : S_SGO;
            end
            S_SGO: begin
                o_cmd.scan_go = 1'b1;
                n_state = S_SWAIT;
            end
            S_SWAIT: begin
                if (!i_sts.scan_busy) begin
                    n_state = S_SUPD;
                end
            end
            S_SUPD: begin
                o_cmd.sel_upd = 1'b1;
                if (r_iter == '0) begin
                    n_state = S_BOUNDS;
                end else begin
                    n_iter  = r_iter - 1'b1;
                    n_state = S_SGO;
                end
            end
            S_BOUNDS: begin
                o_cmd.bounds = 1'b1;
                n_state = S_AGO;
            end
            S_AGO: begin
                o_cmd.scan_go   = 1'b1;
                o_cmd.scan_mode = rtms_pkg::SCAN_SUM;
                n_state = S_AWAIT;
            end
            S_AWAIT: begin
                if (!i_sts.scan_busy) begin
                    n_state = i_sts.kept_zero ? S_OUT : S_MINIT;
                end
            end
            S_MINIT: begin
                o_cmd.div_init = 1'b1;
                n_iter  = '1;
                n_state = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = S_MTAKE;
                end
            end
            S_MTAKE: begin
                o_cmd.mean_take = 1'b1;
                n_state = i_sts.kept_lt2 ? S_OUT : S_QGO;
            end
            S_QGO: begin
                o_cmd.scan_go   = 1'b1;
                o_cmd.scan_mode = rtms_pkg::SCAN_SQ;
                n_state = S_QWAIT;
            end
            S_QWAIT: begin
                if (!i_sts.scan_busy) begin
                    n_state = S_VINIT;
                end
            end
            S_VINIT: begin
                o_cmd.div_init   = 1'b1;
                o_cmd.div_sel_ss = 1'b1;
                n_iter  = '1;
                n_state = S_VDIV;
            end
            S_VDIV: begin
                o_cmd.div_step = 1'b1;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = S_RINIT;
                end
            end
            S_RINIT: begin
                o_cmd.sqrt_init = 1'b1;
                n_iter  = rtms_pkg::ITER_W'(31);
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.sqrt_step = 1'b1;
                n_iter = r_iter - 1'b1;
                if (r_iter == '0) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.set_clear = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_iter  <= '0;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> (r_state == S_IDLE))
        else $error("result strobe lasted more than one cycle");

endmodule

/* rtl/core/rtms_dp.sv */
// ----------------------------------------------------------------------------
// rtms_dp
// Datapath: sample memory, scan pipeline, bitwise order statistic search,
// bounds, accumulators, restoring divider and integer square root.
// ----------------------------------------------------------------------------
module rtms_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rtms_pkg::t_cmd                  i_cmd,
    input  logic [rtms_pkg::SAMPLE_W-1:0]   i_insert_size,
    input  logic                            i_present,
    output rtms_pkg::t_sts                  o_sts,
    output logic [rtms_pkg::CNT_W-1:0]      o_kept_count,
    output logic [rtms_pkg::SAMPLE_W-1:0]   o_mean_size,
    output logic [rtms_pkg::SAMPLE_W-1:0]   o_deviation,
    output logic [rtms_pkg::CNT_W-1:0]      o_total_count,
    output logic                            o_dropped_flag
);

    localparam int unsigned SW = rtms_pkg::SAMPLE_W;
    localparam int unsigned CW = rtms_pkg::CNT_W;
    localparam int unsigned AW = rtms_pkg::ADDR_W;
    localparam logic [17:0] RECIP3 = 18'd174763;

    logic [SW-1:0] r_mem [rtms_pkg::MAX_SAMPLES];

    logic [CW-1:0] r_count;
    logic          r_ovf;

    // Scan pipeline.
    rtms_pkg::t_scan_mode r_mode;
    logic                 r_act, r_v1, r_v2, r_v3;
    logic [AW-1:0]        r_addr;
    logic [SW-1:0]        r_rd, r_s2, r_d2;
    logic                 r_k2, r_k3;
    logic [2*SW-1:0]      r_sq;

    // Order statistic search: median, one third, two thirds.
    logic [CW-1:0] r_k_med, r_k_lo, r_k_hi;
    logic [CW-1:0] r_c_med, r_c_lo, r_c_hi;
    logic [SW-1:0] r_p_med, r_p_lo, r_p_hi;
    logic [SW-1:0] w_bit, w_cand_med, w_cand_lo, w_cand_hi;
    logic [35:0]   w_plo, w_phi;

    logic signed [28:0] r_lo_b, r_hi_b;
    logic [SW:0]        w_gap_lo, w_gap_hi, w_spread;
    logic [26:0]        w_sp5;
    logic signed [28:0] w_s29;
    logic               w_keep;

    logic [CW-1:0]              r_kept;
    logic [rtms_pkg::SUM_W-1:0] r_sum;
    logic [rtms_pkg::SS_W-1:0]  r_ss;
    logic [SW-1:0]              r_mean;

    logic [63:0]   r_num;
    logic [CW-1:0] r_rem, r_den;
    logic [CW:0]   w_trial;
    logic          w_qbit;

    logic [63:0] r_x, r_res, r_bit;
    logic [63:0] w_rb;

    logic [SW-1:0] w_diff;

    assign w_bit      = SW'(1) << i_cmd.iter[4:0];
    assign w_cand_med = r_p_med | w_bit;
    assign w_cand_lo  = r_p_lo  | w_bit;
    assign w_cand_hi  = r_p_hi  | w_bit;
    assign w_plo      = 36'(r_count) * 36'(RECIP3);
    assign w_phi      = 36'({r_count, 1'b0}) * 36'(RECIP3);

    assign w_gap_lo = {1'b0, r_p_med} - {1'b0, r_p_lo};
    assign w_gap_hi = {1'b0, r_p_hi} - {1'b0, r_p_med};
    assign w_spread = (w_gap_lo > w_gap_hi) ? w_gap_lo : w_gap_hi;
    assign w_sp5    = {w_spread[SW-1:0], 2'b00} + 27'(w_spread);

    assign w_s29  = $signed({5'b0, r_rd});
    assign w_keep = (w_s29 >= r_lo_b) && (w_s29 <= r_hi_b);
    assign w_diff = (r_rd >= r_mean) ? (r_rd - r_mean) : (r_mean - r_rd);

    assign w_trial = {r_rem, r_num[63]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_rb    = r_res + r_bit;

    // Sample store and set bookkeeping.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && i_present && !r_count[CW-1]) begin
            r_mem[r_count[AW-1:0]] <= i_insert_size;
        end
        if (r_act) begin
            r_rd <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.set_clear) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.load && i_present) begin
            if (r_count[CW-1]) begin
                r_ovf <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Scan control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            r_v1 <= r_act;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.scan_go) begin
                r_act <= 1'b1;
            end else if (r_act && (({1'b0, r_addr} + 1'b1) == r_count)) begin
                r_act <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_go) begin
            r_addr <= '0;
            r_mode <= i_cmd.scan_mode;
        end else if (r_act) begin
            r_addr <= r_addr + 1'b1;
        end
        r_s2 <= r_rd;
        r_d2 <= w_diff;
        r_k2 <= w_keep;
        r_k3 <= r_k2;
        r_sq <= r_d2 * r_d2;
    end

    // Statistics.
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_init) begin
            r_k_med <= r_count >> 1;
            r_k_lo  <= w_plo[35:19];
            r_k_hi  <= w_phi[35:19];
            r_p_med <= '0;
            r_p_lo  <= '0;
            r_p_hi  <= '0;
            r_kept  <= '0;
            r_mean  <= '0;
            r_res   <= '0;
        end
        if (i_cmd.scan_go) begin
            r_c_med <= '0;
            r_c_lo  <= '0;
            r_c_hi  <= '0;
            if (i_cmd.scan_mode == rtms_pkg::SCAN_SUM) begin
                r_kept <= '0;
                r_sum  <= '0;
            end
            r_ss <= '0;
        end else begin
            if (r_v1 && (r_mode == rtms_pkg::SCAN_SEL)) begin
                r_c_med <= r_c_med + CW'(r_rd < w_cand_med);
                r_c_lo  <= r_c_lo  + CW'(r_rd < w_cand_lo);
                r_c_hi  <= r_c_hi  + CW'(r_rd < w_cand_hi);
            end
            if (r_v2 && r_k2 && (r_mode == rtms_pkg::SCAN_SUM)) begin
                r_kept <= r_kept + 1'b1;
                r_sum  <= r_sum + rtms_pkg::SUM_W'(r_s2);
            end
            if (r_v3 && r_k3 && (r_mode == rtms_pkg::SCAN_SQ)) begin
                r_ss <= r_ss + rtms_pkg::SS_W'(r_sq);
            end
        end
        // A candidate bit stays when few enough samples lie below it.
        if (i_cmd.sel_upd) begin
            if (r_c_med <= r_k_med) begin
                r_p_med <= w_cand_med;
            end
            if (r_c_lo <= r_k_lo) begin
                r_p_lo <= w_cand_lo;
            end
            if (r_c_hi <= r_k_hi) begin
                r_p_hi <= w_cand_hi;
            end
        end
        if (i_cmd.bounds) begin
            r_lo_b <= $signed({5'b0, r_p_med}) - $signed({2'b0, w_sp5});
            r_hi_b <= $signed({5'b0, r_p_med}) + $signed({2'b0, w_sp5});
        end
        if (i_cmd.mean_take) begin
            r_mean <= r_num[SW-1:0];
        end
        if (i_cmd.div_init) begin
            r_num <= i_cmd.div_sel_ss ? r_ss : 64'(r_sum);
            r_den <= i_cmd.div_sel_ss ? (r_kept - 1'b1) : r_kept;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[62:0], w_qbit};
            r_rem <= w_qbit ? CW'(w_trial - {1'b0, r_den}) : w_trial[CW-1:0];
        end
        if (i_cmd.sqrt_init) begin
            r_x   <= r_num;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (i_cmd.sqrt_step) begin
            if (r_x >= w_rb) begin
                r_x   <= r_x - w_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.n_zero    = (r_count == '0);
    assign o_sts.scan_busy = r_act | r_v1 | r_v2 | r_v3;
    assign o_sts.kept_zero = (r_kept == '0);
    assign o_sts.kept_lt2  = (r_kept < CW'(2));

    assign o_kept_count   = r_kept;
    assign o_mean_size    = r_mean;
    assign o_deviation    = r_res[SW-1:0];
    assign o_total_count  = r_count;
    assign o_dropped_flag = r_ovf;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(rtms_pkg::MAX_SAMPLES))
        else $error("sample count beyond capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> ({1'b0, r_addr} < r_count))
        else $error("scan address past stored samples");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

endmodule

/* rtl/core/robust_trimmed_mean_stddev_unit.sv */
// ----------------------------------------------------------------------------
// robust_trimmed_mean_stddev_unit
// Outlier trimmed mean and sample standard deviation of one set of samples.
// ----------------------------------------------------------------------------
// Usage: drive i_insert_size, i_present and i_last with start high; the
// request is taken on a rising edge where busy is low. Each request with
// i_present set stores one sample (up to 65536; later samples are dropped
// and reported through o_dropped_flag). Loading accepts one request per cycle.
// A request with i_last set closes the set; busy then stays high while the
// set is processed and o_valid pulses for one cycle with the result fields.
// Processing runs the three order statistic searches (one memory pass per
// result bit), the filter pass, the mean division, the squared deviation
// pass, the variance division and the square root; the single read port of
// the sample memory sets the pass lengths. An empty set skips processing:
// after the closing request the unit passes through the rank initialisation
// state (S_KINIT) straight to the strobe. The receiver cannot stall: results
// are valid for exactly the strobe cycle. Synchronous reset empties the set
// and returns to idle.
// ----------------------------------------------------------------------------
module robust_trimmed_mean_stddev_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [rtms_pkg::SAMPLE_W-1:0]       i_insert_size,
    input  logic                                i_present,
    input  logic                                i_last,
    output logic                                o_valid,
    output logic [rtms_pkg::CNT_W-1:0]          o_kept_count,
    output logic [rtms_pkg::SAMPLE_W-1:0]       o_mean_size,
    output logic [rtms_pkg::SAMPLE_W-1:0]       o_deviation,
    output logic [rtms_pkg::CNT_W-1:0]          o_total_count,
    output logic                                o_dropped_flag
);

    rtms_pkg::t_cmd w_cmd;
    rtms_pkg::t_sts w_sts;

    rtms_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    rtms_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_insert_size  (i_insert_size),
        .i_present      (i_present),
        .o_sts          (w_sts),
        .o_kept_count   (o_kept_count),
        .o_mean_size    (o_mean_size),
        .o_deviation    (o_deviation),
        .o_total_count  (o_total_count),
        .o_dropped_flag (o_dropped_flag)
    );

endmodule

/* bench/rtms_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtms_checker
// Watches the request and result channels of the trimmed mean unit, predicts
// each result from the accepted requests and compares it field by field.
// ----------------------------------------------------------------------------
module rtms_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [rtms_pkg::SAMPLE_W-1:0] i_insert_size,
    input  logic                          i_present,
    input  logic                          i_last,
    input  logic                          o_valid,
    input  logic [rtms_pkg::CNT_W-1:0]    o_kept_count,
    input  logic [rtms_pkg::SAMPLE_W-1:0] o_mean_size,
    input  logic [rtms_pkg::SAMPLE_W-1:0] o_deviation,
    input  logic [rtms_pkg::CNT_W-1:0]    o_total_count,
    input  logic                          o_dropped_flag,
    output int                            o_pending,
    output int                            o_fail_count
);

    typedef struct packed {
        logic [rtms_pkg::CNT_W-1:0]    kept;
        logic [rtms_pkg::SAMPLE_W-1:0] mean;
        logic [rtms_pkg::SAMPLE_W-1:0] dev;
        logic [rtms_pkg::CNT_W-1:0]    total;
        logic                          dropped;
    } t_stats;

    logic [rtms_pkg::SAMPLE_W-1:0] set_samples[$];
    logic                          set_overflow;
    t_stats                        stats_q[$];

    assign o_pending = stats_q.size();

    function automatic bit [63:0] floor_sqrt(bit [63:0] x);
        bit [63:0] root;
        bit [63:0] probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > x) probe = probe >> 2;
        while (probe != 0) begin
            if (x >= root + probe) begin
                x    = x - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic t_stats trimmed_stats();
        t_stats                        r;
        logic [rtms_pkg::SAMPLE_W-1:0] srt[$];
        int unsigned                   n;
        int unsigned                   kept;
        longint                        med;
        longint                        lo3;
        longint                        hi3;
        longint                        spread;
        longint                        lo_b;
        longint                        hi_b;
        bit [63:0]                     sum;
        bit [63:0]                     mean;
        bit [63:0]                     ss;
        bit [63:0]                     d;
        r    = '0;
        srt  = set_samples;
        n    = unsigned'(srt.size());
        kept = 0;
        sum  = 0;
        mean = 0;
        ss   = 0;
        if (n > 0) begin
            srt.sort();
            med    = longint'(srt[n / 2]);
            lo3    = longint'(srt[n / 3]);
            hi3    = longint'(srt[(n * 2) / 3]);
            spread = (med - lo3 > hi3 - med) ? (med - lo3) : (hi3 - med);
            hi_b   = med + spread * 5;
            lo_b   = med - spread * 5;
            foreach (srt[i]) begin
                if (lo_b <= longint'(srt[i]) && longint'(srt[i]) <= hi_b) begin
                    kept++;
                    sum += 64'(srt[i]);
                end
            end
            if (kept > 0) mean = sum / kept;
            foreach (srt[i]) begin
                if (lo_b <= longint'(srt[i]) && longint'(srt[i]) <= hi_b) begin
                    d  = (64'(srt[i]) >= mean) ? (64'(srt[i]) - mean)
                                               : (mean - 64'(srt[i]));
                    ss += d * d;
                end
            end
            r.kept = rtms_pkg::CNT_W'(kept);
            r.mean = mean[rtms_pkg::SAMPLE_W-1:0];
            if (kept > 1) r.dev = rtms_pkg::SAMPLE_W'(floor_sqrt(ss / (kept - 1)));
        end
        r.total   = rtms_pkg::CNT_W'(n);
        r.dropped = set_overflow;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stats exp_r;
        if (!i_rst_n) begin
            set_samples.delete();
            set_overflow = 1'b0;
            o_fail_count = 0;
        end else begin
            if (o_valid) begin
                if (stats_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result: kept=%0d mean=%0d dev=%0d",
                                 o_kept_count, o_mean_size, o_deviation);
                end else begin
                    exp_r = stats_q.pop_front();
                    if (exp_r.kept !== o_kept_count || exp_r.mean !== o_mean_size ||
                        exp_r.dev !== o_deviation || exp_r.total !== o_total_count ||
                        exp_r.dropped !== o_dropped_flag) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"mismatch exp kept=%0d mean=%0d dev=%0d tot=%0d ",
                                      "drop=%0d act kept=%0d mean=%0d dev=%0d tot=%0d ",
                                      "drop=%0d"},
                                     exp_r.kept, exp_r.mean, exp_r.dev, exp_r.total,
                                     exp_r.dropped, o_kept_count, o_mean_size,
                                     o_deviation, o_total_count, o_dropped_flag);
                    end
                end
            end
            if (start && !busy) begin
                if (i_present) begin
                    if (set_samples.size() < rtms_pkg::MAX_SAMPLES)
                        set_samples.push_back(i_insert_size);
                    else
                        set_overflow = 1'b1;
                end
                if (i_last) begin
                    stats_q.push_back(trimmed_stats());
                    set_samples.delete();
                    set_overflow = 1'b0;
                end
            end
        end
    end
endmodule

/* bench/robust_trimmed_mean_stddev_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robust_trimmed_mean_stddev_unit_tb
// Drives directed and random sample sets into the trimmed mean unit and
// reports the verdict of the checker that runs beside it.
// ----------------------------------------------------------------------------
module robust_trimmed_mean_stddev_unit_tb;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [rtms_pkg::SAMPLE_W-1:0] i_insert_size;
    logic                          i_present;
    logic                          i_last;
    logic                          o_valid;
    logic [rtms_pkg::CNT_W-1:0]    o_kept_count;
    logic [rtms_pkg::SAMPLE_W-1:0] o_mean_size;
    logic [rtms_pkg::SAMPLE_W-1:0] o_deviation;
    logic [rtms_pkg::CNT_W-1:0]    o_total_count;
    logic                          o_dropped_flag;
    int                            pending;
    int                            fail_count;
    bit                            no_gaps;

    robust_trimmed_mean_stddev_unit u_dut (.*);

    rtms_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_insert_size, .i_present, .i_last,
        .o_valid, .o_kept_count, .o_mean_size, .o_deviation, .o_total_count,
        .o_dropped_flag, .o_pending(pending), .o_fail_count(fail_count)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Called at a falling edge; returns at the falling edge after acceptance
    // plus any idle gap.
    task automatic send_request(logic [rtms_pkg::SAMPLE_W-1:0] size, logic pres,
                                logic lst);
        int gap;
        start         <= 1'b1;
        i_insert_size <= size;
        i_present     <= pres;
        i_last        <= lst;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_set(int len, int shape);
        logic [rtms_pkg::SAMPLE_W-1:0] base;
        logic [rtms_pkg::SAMPLE_W-1:0] v;
        int                            roll;
        base = rtms_pkg::SAMPLE_W'($urandom);
        for (int k = 0; k < len; k++) begin
            roll = $urandom_range(0, 99);
            case (shape)
                0: v = rtms_pkg::SAMPLE_W'($urandom);
                1: v = (roll < 85) ? rtms_pkg::SAMPLE_W'(base + $urandom_range(0, 200))
                                   : rtms_pkg::SAMPLE_W'($urandom);
                default: v = (roll < 50) ? 24'hFFFFFF : 24'h0;
            endcase
            send_request(v, ($urandom_range(0, 9) != 0) || (k == len - 1 && roll[0]),
                         k == len - 1);
        end
    endtask

    initial begin
        int items;
        start         = 1'b0;
        i_insert_size = '0;
        i_present     = 1'b0;
        i_last        = 1'b0;
        no_gaps       = 1'b0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty set, then a lone maximum and a lone zero sample, each carried by the last request.
        send_request(24'h123456, 1'b0, 1'b1);
        send_request(24'hFFFFFF, 1'b1, 1'b1);
        send_request(24'h0, 1'b1, 1'b1);
        // Equal samples with an idle request in between: the spread is zero.
        send_request(24'd1000, 1'b1, 1'b0);
        send_request(24'd7, 1'b0, 1'b0);
        send_request(24'd1000, 1'b1, 1'b0);
        send_request(24'd1000, 1'b1, 1'b1);
        // Tight cluster with two far outliers that the bounds must cut.
        send_request(24'd500, 1'b1, 1'b0);
        send_request(24'd502, 1'b1, 1'b0);
        send_request(24'd501, 1'b1, 1'b0);
        send_request(24'd503, 1'b1, 1'b0);
        send_request(24'd499, 1'b1, 1'b0);
        send_request(24'hFFFFFF, 1'b1, 1'b0);
        send_request(24'd0, 1'b1, 1'b1);
        // Two samples: both extremes.
        send_request(24'hFFFFFF, 1'b1, 1'b0);
        send_request(24'h000000, 1'b1, 1'b1);
        // Set closed by a request without a sample.
        send_request(24'h0F0F0F, 1'b1, 1'b0);
        send_request(24'hF0F0F0, 1'b1, 1'b0);
        send_request(24'h000000, 1'b0, 1'b1);

        items = 0;
        while (items < 1780) begin
            int len;
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                  : $urandom_range(4, 40);
            no_gaps = ($urandom_range(0, 3) == 0);
            send_set(len, $urandom_range(0, 2));
            items += len;
        end
        start <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
